@@ hw/rtl/mwsh_pkg.sv @@
// Shared constants, step codes and control structs of the whitespace-stripped hash block.
package mwsh_pkg;

   localparam logic [31:0] MIX_M = 32'h5BD1_E995;
   localparam logic [31:0] SEED  = 32'h0000_0001;

   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;

   localparam logic CMD_COUNT = 1'b0;
   localparam logic CMD_HASH  = 1'b1;

   localparam logic [2:0] STEP_NONE = 3'd0;
   localparam logic [2:0] STEP_MIX1 = 3'd1;
   localparam logic [2:0] STEP_MIX2 = 3'd2;
   localparam logic [2:0] STEP_MIX3 = 3'd3;
   localparam logic [2:0] STEP_FIN0 = 3'd4;
   localparam logic [2:0] STEP_FIN1 = 3'd5;

   typedef struct packed {
      logic       accept;
      logic [2:0] step;
   } cmd_type;

   typedef struct packed {
      logic mix_needed;
      logic fin_needed;
      logic out_free;
   } status_type;

   function automatic logic is_dropped(input logic [7:0] b);
      is_dropped = (b == CHAR_TAB) || (b == CHAR_LF) || (b == CHAR_CR) || (b == CHAR_SPACE);
   endfunction

endpackage

@@ hw/rtl/mwsh_ctrl.sv @@
// Sequencer of the whitespace-stripped hash block: accept, word mix and finalise steps.
module mwsh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mwsh_pkg::status_type status,
   output mwsh_pkg::cmd_type    cmd
);
   import mwsh_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MIX1 = 3'd1;
   localparam logic [2:0] ST_MIX2 = 3'd2;
   localparam logic [2:0] ST_MIX3 = 3'd3;
   localparam logic [2:0] ST_FIN0 = 3'd4;
   localparam logic [2:0] ST_FIN1 = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       last_pend_ff, last_pend_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      last_pend_in = last_pend_ff;
      cmd.accept   = accept;
      cmd.step     = STEP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (status.mix_needed) begin
                  state_in     = ST_MIX1;
                  last_pend_in = status.fin_needed;
               end else if (status.fin_needed) begin
                  state_in = ST_FIN0;
               end
            end
         end
         ST_MIX1: begin
            cmd.step = STEP_MIX1;
            state_in = ST_MIX2;
         end
         ST_MIX2: begin
            cmd.step = STEP_MIX2;
            state_in = ST_MIX3;
         end
         ST_MIX3: begin
            cmd.step = STEP_MIX3;
            state_in = last_pend_ff ? ST_FIN0 : ST_IDLE;
         end
         ST_FIN0: begin
            cmd.step = STEP_FIN0;
            state_in = ST_FIN1;
         end
         ST_FIN1: begin
            // hold until the result register is free
            if (status.out_free) begin
               cmd.step = STEP_FIN1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_pend_ff <= last_pend_in;
      end
   end

`ifndef ASSERT_OFF
   a_full_word_mixes: assert property (@(posedge clock) disable iff (reset)
      (accept && status.mix_needed) |=> (state_ff == ST_MIX1))
      else $error("full word did not start the mix sequence");
   a_mix_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX3 && !last_pend_ff) |=> (state_ff == ST_IDLE))
      else $error("mix without last beat did not return to idle");
   a_fin_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN0) |=> (state_ff == ST_FIN1))
      else $error("finalise steps out of order");
`endif

endmodule

@@ hw/rtl/mwsh_datapath.sv @@
// Datapath of the whitespace-stripped hash block: counters, word packing, shared multiplier.
module mwsh_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  mwsh_pkg::cmd_type    cmd,
   output mwsh_pkg::status_type status,
   input  logic                 req_cmd,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_byte_valid,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_hash,
   output logic [31:0]          rsp_kept_length
);
   import mwsh_pkg::*;

   logic [31:0] kept_count_ff, kept_count_in;
   logic [31:0] hash_acc_ff, hash_acc_in;
   logic [23:0] word_ff, word_in;
   logic [1:0]  biw_ff, biw_in;
   logic        started_ff, started_in;
   logic [31:0] k_ff, k_in;
   logic [31:0] h_ff, h_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_hash_ff, rsp_hash_in;
   logic [31:0] rsp_len_ff, rsp_len_in;

   logic        kept;
   logic [23:0] eff_word;
   logic [1:0]  eff_biw;
   logic [23:0] byte_shifted;
   logic [31:0] mul_a, mul_p, fin_t;

   assign kept     = req_byte_valid && !is_dropped(req_data_byte);
   assign eff_word = started_ff ? word_ff : 24'd0;
   assign eff_biw  = started_ff ? biw_ff : 2'd0;
   assign byte_shifted = {16'd0, req_data_byte} << {eff_biw, 3'b000};

   assign status.mix_needed = (req_cmd == CMD_HASH) && kept && (eff_biw == 2'd3);
   assign status.fin_needed = (req_cmd == CMD_HASH) && req_last;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   // one shared multiplier, operand chosen by the step in progress
   always_comb begin
      case (cmd.step)
         STEP_MIX1, STEP_MIX2: mul_a = k_ff;
         STEP_MIX3:            mul_a = hash_acc_ff;
         STEP_FIN0:            mul_a = hash_acc_ff ^ {8'd0, word_ff};
         STEP_FIN1:            mul_a = h_ff;
         default:              mul_a = k_ff;
      endcase
   end

   assign mul_p = mul_a * MIX_M;
   assign fin_t = (biw_ff != 2'd0) ? mul_p : hash_acc_ff;

   always_comb begin
      kept_count_in = kept_count_ff;
      hash_acc_in   = hash_acc_ff;
      word_in       = word_ff;
      biw_in        = biw_ff;
      started_in    = started_ff;
      k_in          = k_ff;
      h_in          = h_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_hash_in   = rsp_hash_ff;
      rsp_len_in    = rsp_len_ff;

      if (cmd.accept) begin
         if (req_cmd == CMD_COUNT) begin
            // abandon any unfinished hashing pass
            if (started_ff) begin
               hash_acc_in = 32'd0;
               word_in     = 24'd0;
               biw_in      = 2'd0;
               started_in  = 1'b0;
            end
            if (kept) begin
               kept_count_in = kept_count_ff + 32'd1;
            end
         end else begin
            started_in = 1'b1;
            if (!started_ff) begin
               hash_acc_in = SEED ^ kept_count_ff;
               word_in     = 24'd0;
               biw_in      = 2'd0;
            end
            if (kept) begin
               if (eff_biw == 2'd3) begin
                  k_in    = {req_data_byte, eff_word};
                  word_in = 24'd0;
                  biw_in  = 2'd0;
               end else begin
                  word_in = eff_word | byte_shifted;
                  biw_in  = eff_biw + 2'd1;
               end
            end
         end
      end

      case (cmd.step)
         STEP_MIX1: k_in = mul_p ^ (mul_p >> 24);
         STEP_MIX2: k_in = mul_p;
         STEP_MIX3: hash_acc_in = mul_p ^ k_ff;
         STEP_FIN0: h_in = fin_t ^ (fin_t >> 13);
         STEP_FIN1: begin
            rsp_hash_in   = mul_p ^ (mul_p >> 15);
            rsp_len_in    = kept_count_ff;
            rsp_valid_in  = 1'b1;
            kept_count_in = 32'd0;
            hash_acc_in   = 32'd0;
            word_in       = 24'd0;
            biw_in        = 2'd0;
            started_in    = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_count_ff <= 32'd0;
         hash_acc_ff   <= 32'd0;
         word_ff       <= 24'd0;
         biw_ff        <= 2'd0;
         started_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         kept_count_ff <= kept_count_in;
         hash_acc_ff   <= hash_acc_in;
         word_ff       <= word_in;
         biw_ff        <= biw_in;
         started_ff    <= started_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      h_ff        <= h_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_len_ff  <= rsp_len_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hash        = rsp_hash_ff;
   assign rsp_kept_length = rsp_len_ff;

`ifndef ASSERT_OFF
   a_result_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == STEP_FIN1) |=> (kept_count_ff == 32'd0 && !started_ff && rsp_valid_ff))
      else $error("state not cleared after a result");
   a_fin1_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == STEP_FIN1) |-> status.out_free)
      else $error("result written while the output register was full");
`endif

endmodule

@@ hw/rtl/murmur2_whitespace_stripped_hash.sv @@
// Top level of the whitespace-stripped 32-bit MurmurHash2 fingerprint block (seed 1).
//
//   channel | ports                                              | direction
//   --------+----------------------------------------------------+----------
//   req     | req_valid/ready, cmd, data_byte, byte_valid, last  | in
//   rsp     | rsp_valid/ready, hash, kept_length                 | out
//
// A beat that completes no word needs no multiplier step. A kept byte that fills a word
// adds two key mixes and one hash mix on the single shared 32x32 multiplier.
// The last hashing beat adds the finalise steps FIN0 and FIN1 on the same multiplier.
// Reset clears the count and the hashing state at once; no clearing pass is needed.
// The result sits in an output register, so req_ready returns while a result waits;
// a second result holds in the last finalise step until the first is taken.
module murmur2_whitespace_stripped_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_hash,
   output logic [31:0] rsp_kept_length
);
   import mwsh_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: decides accept, mix and finalise steps
   mwsh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: count, pack bytes, run the shared multiplier, hold the result
   mwsh_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_cmd         (req_cmd),
      .req_data_byte   (req_data_byte),
      .req_byte_valid  (req_byte_valid),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hash        (rsp_hash),
      .rsp_kept_length (rsp_kept_length)
   );

endmodule
